// ----- src/tsrl_pkg.sv -----
// shared types, widths and codes of the tileset source rectangle lookup
package tsrl_pkg;

    localparam int MAX_SETS_DEF = 8;

    localparam int CMD_W    = 2;
    localparam int ID_W     = 24;
    localparam int TOTAL_W  = 17;
    localparam int CELL_W   = 11;
    localparam int BORDER_W = 10;
    localparam int COLS_W   = 12;
    localparam int TEX_W    = 16;
    localparam int POS_W    = 32;
    localparam int STEP_W   = 12;
    localparam int REL_W    = ID_W + 1;
    localparam int PRODX_W  = STEP_W + COLS_W;
    localparam int PRODY_W  = STEP_W + ID_W;
    localparam int SUM_W    = PRODY_W + 2;

    localparam int S_TDATA_W = 136;
    localparam int M_TDATA_W = 104;

    typedef enum logic [CMD_W-1:0] {
        CMD_APPEND = 2'd0,
        CMD_LOOKUP = 2'd1,
        CMD_CLEAR  = 2'd2
    } cmd_e;

    typedef struct packed {
        logic [ID_W-1:0]            first_id;
        logic signed [TOTAL_W-1:0]  tile_total;
        logic [CELL_W-1:0]          cell_width;
        logic [CELL_W-1:0]          cell_height;
        logic [BORDER_W-1:0]        border;
        logic [BORDER_W-1:0]        gap;
        logic [COLS_W-1:0]          atlas_columns;
        logic [TEX_W-1:0]           atlas_texture;
    } entry_t;

    typedef struct packed {
        logic table_write;
        logic table_clear;
        logic lookup_load;
        logic idx_inc;
        logic div_start;
        logic mul_load;
        logic out_load;
        logic out_found;
    } ctrl_cmd_t;

    typedef struct packed {
        logic empty;
        logic below_first;
        logic entry_hit;
        logic last_entry;
        logic cols_zero;
        logic div_done;
    } ctrl_sts_t;

endpackage

// ----- src/tsrl_div.sv -----
// serial restoring divider, one quotient bit per cycle
module tsrl_div (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        start,
    input  logic [tsrl_pkg::ID_W-1:0]   dividend,
    input  logic [tsrl_pkg::COLS_W-1:0] divisor,
    output logic [tsrl_pkg::ID_W-1:0]   quotient,
    output logic [tsrl_pkg::COLS_W-1:0] remainder,
    output logic                        done
);

    localparam int DivW = tsrl_pkg::ID_W;
    localparam int RemW = tsrl_pkg::COLS_W;
    localparam int CntW = $clog2(DivW);

    logic            busy_reg;
    logic            done_reg;
    logic [CntW-1:0] cnt_reg;
    logic [RemW-1:0] rem_reg;
    logic [DivW-1:0] quo_reg;

    logic [RemW:0]   trial;
    logic            ge;
    logic [RemW:0]   diff;
    logic [RemW-1:0] rem_next;
    logic [DivW-1:0] quo_next;

    always_comb begin
        trial    = {rem_reg, quo_reg[DivW-1]};
        ge       = trial >= {1'b0, divisor};
        diff     = trial - {1'b0, divisor};
        rem_next = ge ? diff[RemW-1:0] : trial[RemW-1:0];
        quo_next = {quo_reg[DivW-2:0], ge};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= busy_reg && !start && (cnt_reg == CntW'(DivW - 1));
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CntW'(DivW - 1)) begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg <= '0;
            quo_reg <= dividend;
        end else if (busy_reg) begin
            rem_reg <= rem_next;
            quo_reg <= quo_next;
        end
    end

    assign quotient  = quo_reg;
    assign remainder = rem_reg;
    assign done      = done_reg;

endmodule

// ----- src/tsrl_dpath.sv -----
// tileset table, search compare, divide, multiply and result register
module tsrl_dpath #(
    parameter int MaxSets = tsrl_pkg::MAX_SETS_DEF
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  tsrl_pkg::ctrl_cmd_t         cmd,
    output tsrl_pkg::ctrl_sts_t         sts,
    input  tsrl_pkg::entry_t            entry_in,
    input  logic [tsrl_pkg::ID_W-1:0]   lookup_id,
    output logic                        found,
    output logic [tsrl_pkg::POS_W-1:0]  src_x,
    output logic [tsrl_pkg::POS_W-1:0]  src_y,
    output logic [tsrl_pkg::CELL_W-1:0] src_w,
    output logic [tsrl_pkg::CELL_W-1:0] src_h,
    output logic [tsrl_pkg::TEX_W-1:0]  texture_handle
);

    localparam int IdxW    = (MaxSets > 1) ? $clog2(MaxSets) : 1;
    localparam int CntW    = $clog2(MaxSets + 1);
    localparam int ID_W    = tsrl_pkg::ID_W;
    localparam int REL_W   = tsrl_pkg::REL_W;
    localparam int STEP_W  = tsrl_pkg::STEP_W;
    localparam int SUM_W   = tsrl_pkg::SUM_W;
    localparam int POS_W   = tsrl_pkg::POS_W;

    localparam logic signed [SUM_W-1:0] SatHi = SUM_W'(64'sd2147483647);
    localparam logic signed [SUM_W-1:0] SatLo = -SatHi - SUM_W'(1);

    tsrl_pkg::entry_t table_mem [MaxSets];
    tsrl_pkg::entry_t rd_reg;

    logic [CntW-1:0]                 count_reg;
    logic [IdxW-1:0]                 idx_reg;
    logic [ID_W-1:0]                 id_reg;
    logic                            neg_reg;
    logic [tsrl_pkg::PRODX_W-1:0]    prod_x_reg;
    logic [tsrl_pkg::PRODY_W-1:0]    prod_y_reg;

    logic                            found_reg;
    logic [POS_W-1:0]                x_reg;
    logic [POS_W-1:0]                y_reg;
    logic [tsrl_pkg::CELL_W-1:0]     w_reg;
    logic [tsrl_pkg::CELL_W-1:0]     h_reg;
    logic [tsrl_pkg::TEX_W-1:0]      tex_reg;

    logic                            write_en;
    logic [REL_W-1:0]                rel;
    logic [REL_W-1:0]                rel_mag;
    logic [REL_W-1:0]                range_end;
    logic [STEP_W-1:0]               step_x;
    logic [STEP_W-1:0]               step_y;
    logic signed [SUM_W-1:0]         sum_x;
    logic signed [SUM_W-1:0]         sum_y;
    logic [ID_W-1:0]                 div_quo;
    logic [tsrl_pkg::COLS_W-1:0]     div_rem;
    logic                            div_done;

    function automatic logic [POS_W-1:0] sat32(input logic signed [SUM_W-1:0] v);
        logic [POS_W-1:0] r;
        if (v > SatHi) begin
            r = SatHi[POS_W-1:0];
        end else if (v < SatLo) begin
            r = SatLo[POS_W-1:0];
        end else begin
            r = v[POS_W-1:0];
        end
        return r;
    endfunction

    assign write_en = cmd.table_write && (count_reg < CntW'(MaxSets));

    // table: one write port at the fill count, one registered read at the walk index
    always_ff @(posedge aclk) begin
        if (write_en) begin
            table_mem[count_reg[IdxW-1:0]] <= entry_in;
        end
        rd_reg <= table_mem[idx_reg];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else if (cmd.table_clear) begin
            count_reg <= '0;
        end else if (write_en) begin
            count_reg <= count_reg + 1'b1;
        end
    end

    // search compare on the registered entry
    always_comb begin
        range_end = {1'b0, rd_reg.first_id} + REL_W'(rd_reg.tile_total[tsrl_pkg::TOTAL_W-2:0]);
        rel       = {1'b0, id_reg} - {1'b0, rd_reg.first_id};
        rel_mag   = rel[REL_W-1] ? (~rel + 1'b1) : rel;
        step_x    = STEP_W'(rd_reg.cell_width) + STEP_W'(rd_reg.gap);
        step_y    = STEP_W'(rd_reg.cell_height) + STEP_W'(rd_reg.gap);

        sts.empty       = (count_reg == '0);
        sts.below_first = (idx_reg == '0) && (id_reg < rd_reg.first_id);
        sts.entry_hit   = rd_reg.tile_total[tsrl_pkg::TOTAL_W-1] ||
                          ({1'b0, id_reg} < range_end);
        sts.last_entry  = ((CntW'(idx_reg) + 1'b1) == count_reg);
        sts.cols_zero   = (rd_reg.atlas_columns == '0);
        sts.div_done    = div_done;
    end

    always_ff @(posedge aclk) begin
        if (cmd.lookup_load) begin
            id_reg <= lookup_id;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg <= '0;
        end else if (cmd.lookup_load) begin
            idx_reg <= '0;
        end else if (cmd.idx_inc) begin
            idx_reg <= idx_reg + 1'b1;
        end
    end

    // sign of the relative id, division works on magnitudes
    always_ff @(posedge aclk) begin
        if (cmd.div_start) begin
            neg_reg <= rel[REL_W-1];
        end
    end

    tsrl_div u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (cmd.div_start),
        .dividend  (rel_mag[ID_W-1:0]),
        .divisor   (rd_reg.atlas_columns),
        .quotient  (div_quo),
        .remainder (div_rem),
        .done      (div_done)
    );

    always_ff @(posedge aclk) begin
        if (cmd.mul_load) begin
            prod_x_reg <= step_x * div_rem;
            prod_y_reg <= step_y * div_quo;
        end
    end

    always_comb begin
        sum_x = neg_reg ? ($signed(SUM_W'(rd_reg.border)) - $signed(SUM_W'(prod_x_reg)))
                        : ($signed(SUM_W'(rd_reg.border)) + $signed(SUM_W'(prod_x_reg)));
        sum_y = neg_reg ? ($signed(SUM_W'(rd_reg.border)) - $signed(SUM_W'(prod_y_reg)))
                        : ($signed(SUM_W'(rd_reg.border)) + $signed(SUM_W'(prod_y_reg)));
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            if (cmd.out_found) begin
                found_reg <= 1'b1;
                x_reg     <= sat32(sum_x);
                y_reg     <= sat32(sum_y);
                w_reg     <= rd_reg.cell_width;
                h_reg     <= rd_reg.cell_height;
                tex_reg   <= rd_reg.atlas_texture;
            end else begin
                found_reg <= 1'b0;
                x_reg     <= '0;
                y_reg     <= '0;
                w_reg     <= '0;
                h_reg     <= '0;
                tex_reg   <= '0;
            end
        end
    end

    assign found          = found_reg;
    assign src_x          = x_reg;
    assign src_y          = y_reg;
    assign src_w          = w_reg;
    assign src_h          = h_reg;
    assign texture_handle = tex_reg;

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CntW'(MaxSets))
        else $error("table fill count beyond table depth");

    a_append_grows: assert property (@(posedge aclk) disable iff (!aresetn)
        write_en && !cmd.table_clear |=> count_reg == $past(count_reg) + 1'b1)
        else $error("append did not advance the fill count");

    a_found_cols: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load && cmd.out_found |-> rd_reg.atlas_columns != '0)
        else $error("found result from a tileset with zero columns");

    a_div_before_mul: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.mul_load |-> $past(div_done))
        else $error("multiply loaded without a finished divide");

endmodule

// ----- src/tsrl_ctrl.sv -----
// command sequencer: accepts items, walks the table, runs divide and multiply
module tsrl_ctrl (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      s_tvalid,
    output logic                      s_tready,
    input  logic [tsrl_pkg::CMD_W-1:0] command,
    output logic                      m_tvalid,
    input  logic                      m_tready,
    output tsrl_pkg::ctrl_cmd_t       cmd,
    input  tsrl_pkg::ctrl_sts_t       sts
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FETCH,
        ST_CHECK,
        ST_DIVIDE,
        ST_MULT,
        ST_DONE
    } state_t;

    state_t state_reg, state_next;
    logic   hit_reg, hit_next;
    logic   out_valid_reg, out_valid_next;

    always_comb begin
        state_next = state_reg;
        hit_next   = hit_reg;
        cmd        = '0;
        s_tready   = 1'b0;

        case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    case (command)
                        tsrl_pkg::CMD_APPEND: begin
                            cmd.table_write = 1'b1;
                        end
                        tsrl_pkg::CMD_CLEAR: begin
                            cmd.table_clear = 1'b1;
                        end
                        tsrl_pkg::CMD_LOOKUP: begin
                            cmd.lookup_load = 1'b1;
                            if (sts.empty) begin
                                hit_next   = 1'b0;
                                state_next = ST_DONE;
                            end else begin
                                state_next = ST_FETCH;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_FETCH: begin
                state_next = ST_CHECK;
            end
            ST_CHECK: begin
                if (sts.below_first) begin
                    hit_next   = 1'b0;
                    state_next = ST_DONE;
                end else if (sts.entry_hit) begin
                    if (sts.cols_zero) begin
                        hit_next   = 1'b0;
                        state_next = ST_DONE;
                    end else begin
                        cmd.div_start = 1'b1;
                        state_next    = ST_DIVIDE;
                    end
                end else if (sts.last_entry) begin
                    hit_next   = 1'b0;
                    state_next = ST_DONE;
                end else begin
                    cmd.idx_inc = 1'b1;
                    state_next  = ST_FETCH;
                end
            end
            ST_DIVIDE: begin
                if (sts.div_done) begin
                    state_next = ST_MULT;
                end
            end
            ST_MULT: begin
                cmd.mul_load = 1'b1;
                hit_next     = 1'b1;
                state_next   = ST_DONE;
            end
            ST_DONE: begin
                if (!out_valid_reg || m_tready) begin
                    cmd.out_load  = 1'b1;
                    cmd.out_found = hit_reg;
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        if (cmd.out_load) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end else begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            hit_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            hit_reg       <= hit_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign m_tvalid = out_valid_reg;

endmodule

// ----- src/tileset_source_rect_lookup.sv -----
// top level of the tileset source rectangle lookup
// Resolves global tile ids to atlas source rectangles against a table of up to
// MAX_SETS tilesets. s_tuser carries the command: append a tileset entry at the
// end of the table (ignored when full), look up a tile id, or clear the table;
// the fourth code is dropped. Only a lookup produces a result transfer on the
// m_ side, with m_tuser as the found flag and an all-zero rectangle when the
// table is empty, the id is below the first tileset or past every range, or
// the id hits a tileset with zero columns. Append, clear and the unused code
// are taken in idle without leaving it. A lookup walks the table from index 0,
// and each entry examined passes through a fetch and a check state because the
// table is a memory with a registered read port. On a hit the column/row split
// of the relative id is done in a bit-serial divider (24 quotient bits), then
// come a multiply state and a result state. A miss or a zero column count skips
// the divide and goes to the result state, as does a lookup on an empty table.
// The block is back in idle in the cycle after the result is loaded. A finished
// result sits in the output register while the next item is taken in; a lookup
// that finishes while that result is still waiting holds in its result state
// until the result transfer happens. The block takes one item at a time.
module tileset_source_rect_lookup #(
    parameter int MAX_SETS = tsrl_pkg::MAX_SETS_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // first_id, tile_total, cell_width, cell_height, border, gap,
    // atlas_columns, atlas_texture, lookup_id, zero pad
    input  logic [tsrl_pkg::S_TDATA_W-1:0]    s_tdata,
    // command
    input  logic [tsrl_pkg::CMD_W-1:0]        s_tuser,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // src_x, src_y, src_w, src_h, texture_handle, zero pad
    output logic [tsrl_pkg::M_TDATA_W-1:0]    m_tdata,
    // found
    output logic                              m_tuser
);

    tsrl_pkg::ctrl_cmd_t         cmd;
    tsrl_pkg::ctrl_sts_t         sts;
    tsrl_pkg::entry_t            entry_in;
    logic [tsrl_pkg::ID_W-1:0]   lookup_id;

    logic                        found;
    logic [tsrl_pkg::POS_W-1:0]  src_x;
    logic [tsrl_pkg::POS_W-1:0]  src_y;
    logic [tsrl_pkg::CELL_W-1:0] src_w;
    logic [tsrl_pkg::CELL_W-1:0] src_h;
    logic [tsrl_pkg::TEX_W-1:0]  texture_handle;

    // unpack the input transfer, lowest field first
    always_comb begin
        entry_in.first_id      = s_tdata[23:0];
        entry_in.tile_total    = s_tdata[40:24];
        entry_in.cell_width    = s_tdata[51:41];
        entry_in.cell_height   = s_tdata[62:52];
        entry_in.border        = s_tdata[72:63];
        entry_in.gap           = s_tdata[82:73];
        entry_in.atlas_columns = s_tdata[94:83];
        entry_in.atlas_texture = s_tdata[110:95];
        lookup_id              = s_tdata[134:111];
    end

    tsrl_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .command  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd),
        .sts      (sts)
    );

    tsrl_dpath #(
        .MaxSets (MAX_SETS)
    ) u_dpath (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cmd            (cmd),
        .sts            (sts),
        .entry_in       (entry_in),
        .lookup_id      (lookup_id),
        .found          (found),
        .src_x          (src_x),
        .src_y          (src_y),
        .src_w          (src_w),
        .src_h          (src_h),
        .texture_handle (texture_handle)
    );

    // pack the result transfer, lowest field first
    assign m_tdata = {2'b00, texture_handle, src_h, src_w, src_y, src_x};
    assign m_tuser = found;

endmodule

// ----- bench/tileset_source_rect_lookup_test.sv -----
// self-checking bench for the tileset source rectangle lookup
`timescale 1ns / 100ps

module tileset_source_rect_lookup_test;

    typedef logic [tsrl_pkg::CMD_W-1:0] cmd_t;
    typedef logic [tsrl_pkg::ID_W-1:0]  id_t;

    // the fourth command code, which the block drops without a result
    localparam cmd_t CMD_UNUSED     = 2'd3;
    localparam int MAX_ID         = 24'hFFFFFF;
    localparam int ITEM_TARGET    = 1650;
    localparam int LONG_HOLD      = 400;     // receiver hold-off for the stall test
    localparam int WATCHDOG_LIMIT = 4000;    // cycles with no transfer on either side
    localparam int SETTLE_CYCLES  = 64;

    typedef enum int {PACE_FULL, PACE_LIGHT, PACE_HEAVY} pace_e;

    // one result transfer, unpacked
    typedef struct packed {
        logic                        found;
        logic [tsrl_pkg::POS_W-1:0]  x;
        logic [tsrl_pkg::POS_W-1:0]  y;
        logic [tsrl_pkg::CELL_W-1:0] w;
        logic [tsrl_pkg::CELL_W-1:0] h;
        logic [tsrl_pkg::TEX_W-1:0]  tex;
    } rect_t;

    // tracks the tileset table and the rectangles owed by the block
    class atlas_rect_checker;
        tsrl_pkg::entry_t tiles[tsrl_pkg::MAX_SETS_DEF];
        int     n_sets;
        rect_t  pending_rects[$];
        int     errors, lookups, found_cnt, clamped, dropped_appends, results_seen;

        function new();
            n_sets = 0;
            errors = 0;
            lookups = 0;
            found_cnt = 0;
            clamped = 0;
            dropped_appends = 0;
            results_seen = 0;
        endfunction

        function logic [tsrl_pkg::POS_W-1:0] clamp32(longint v);
            if (v > 64'sd2147483647) begin
                clamped++;
                return 32'h7FFFFFFF;
            end
            if (v < -64'sd2147483648) begin
                clamped++;
                return 32'h80000000;
            end
            return v[tsrl_pkg::POS_W-1:0];
        endfunction

        // first entry whose range holds the id, or whose count is unknown
        function rect_t resolve_tile(id_t id);
            rect_t  r;
            int     hit;
            longint rel, col, row, cols, px, py;
            r = '0;
            hit = -1;
            lookups++;
            if (n_sets == 0 || id < tiles[0].first_id) return r;
            for (int k = 0; k < n_sets; k++) begin
                if (hit < 0 && ($signed(tiles[k].tile_total) < 0 ||
                        longint'(id) < longint'(tiles[k].first_id) +
                        longint'($signed(tiles[k].tile_total))))
                    hit = k;
            end
            if (hit < 0 || tiles[hit].atlas_columns == 0) return r;
            cols = longint'(tiles[hit].atlas_columns);
            // id may lie below the taken entry: division truncates toward zero
            rel = longint'(id) - longint'(tiles[hit].first_id);
            col = rel % cols;
            row = rel / cols;
            px = longint'(tiles[hit].border) +
                 (longint'(tiles[hit].cell_width) + longint'(tiles[hit].gap)) * col;
            py = longint'(tiles[hit].border) +
                 (longint'(tiles[hit].cell_height) + longint'(tiles[hit].gap)) * row;
            r.found = 1'b1;
            r.x = clamp32(px);
            r.y = clamp32(py);
            r.w = tiles[hit].cell_width;
            r.h = tiles[hit].cell_height;
            r.tex = tiles[hit].atlas_texture;
            found_cnt++;
            return r;
        endfunction

        // called for every input transfer the block accepts
        function void accept_command(cmd_t cmd, tsrl_pkg::entry_t e, id_t id);
            case (cmd)
                tsrl_pkg::CMD_APPEND: begin
                    if (n_sets < tsrl_pkg::MAX_SETS_DEF) begin
                        tiles[n_sets] = e;
                        n_sets++;
                    end else begin
                        dropped_appends++;
                    end
                end
                tsrl_pkg::CMD_CLEAR: n_sets = 0;
                tsrl_pkg::CMD_LOOKUP: pending_rects.insert(pending_rects.size(), resolve_tile(id));
                default: ;
            endcase
        endfunction

        task report_mismatch(string what, logic [tsrl_pkg::POS_W-1:0] got,
                             logic [tsrl_pkg::POS_W-1:0] want);
            if (errors < 40)
                $display("%0t mismatch in %s: got %0h, expected %0h", $realtime, what, got, want);
            errors++;
        endtask

        task check_rect(logic found, logic [tsrl_pkg::M_TDATA_W-1:0] d);
            rect_t want;
            results_seen++;
            if (pending_rects.size() == 0) begin
                report_mismatch("result with no lookup waiting", {31'd0, found}, 32'd0);
            end else begin
                want = pending_rects.pop_front();
                if (found !== want.found) report_mismatch("found", {31'd0, found}, {31'd0, want.found});
                if (d[31:0] !== want.x) report_mismatch("src_x", d[31:0], want.x);
                if (d[63:32] !== want.y) report_mismatch("src_y", d[63:32], want.y);
                if (d[74:64] !== want.w) report_mismatch("src_w", {21'd0, d[74:64]}, {21'd0, want.w});
                if (d[85:75] !== want.h) report_mismatch("src_h", {21'd0, d[85:75]}, {21'd0, want.h});
                if (d[101:86] !== want.tex)
                    report_mismatch("texture_handle", {16'd0, d[101:86]}, {16'd0, want.tex});
            end
        endtask
    endclass

    // clock, 2 ns period
    logic aclk = 1'b0;
    always #1 aclk = ~aclk;

    logic                           aresetn = 1'b0;
    logic                           s_tvalid = 1'b0;
    logic                           s_tready;
    // first_id, tile_total, cell_width, cell_height, border, gap,
    // atlas_columns, atlas_texture, lookup_id, zero pad
    logic [tsrl_pkg::S_TDATA_W-1:0] s_tdata = '0;
    // command
    cmd_t                           s_tuser = '0;
    logic                           m_tvalid;
    logic                           m_tready = 1'b0;
    // src_x, src_y, src_w, src_h, texture_handle, zero pad
    logic [tsrl_pkg::M_TDATA_W-1:0] m_tdata;
    // found
    logic                           m_tuser;

    tileset_source_rect_lookup uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    atlas_rect_checker sb = new();

    pace_e src_pace  = PACE_FULL;
    pace_e sink_pace = PACE_FULL;
    bit    sink_hold_req = 1'b0;
    int    items_sent = 0;
    int    quiet_cycles = 0;

    // no gap at full pace, else a mix of none and short gaps with a few long ones
    function automatic int pick_gap(pace_e pace);
        int r;
        r = $urandom_range(0, 99);
        if (pace == PACE_FULL) return 0;
        if (r < ((pace == PACE_LIGHT) ? 70 : 35)) return 0;
        if (r < 94) return $urandom_range(1, 4);
        return $urandom_range(10, 48);
    endfunction

    function automatic tsrl_pkg::entry_t make_entry(int first, int total, int cw, int ch,
                                                    int border, int gap, int cols, int tex);
        tsrl_pkg::entry_t e;
        e.first_id      = first[tsrl_pkg::ID_W-1:0];
        e.tile_total    = total[tsrl_pkg::TOTAL_W-1:0];
        e.cell_width    = cw[tsrl_pkg::CELL_W-1:0];
        e.cell_height   = ch[tsrl_pkg::CELL_W-1:0];
        e.border        = border[tsrl_pkg::BORDER_W-1:0];
        e.gap           = gap[tsrl_pkg::BORDER_W-1:0];
        e.atlas_columns = cols[tsrl_pkg::COLS_W-1:0];
        e.atlas_texture = tex[tsrl_pkg::TEX_W-1:0];
        return e;
    endfunction

    // random tileset at the given first id, small ranges dominate
    function automatic tsrl_pkg::entry_t random_entry(int first);
        int r, total, cols;
        r = $urandom_range(0, 99);
        total = (r < 10) ? -1 : (r < 22) ? $urandom_range(0, 65535) : $urandom_range(0, 400);
        r = $urandom_range(0, 99);
        cols = (r < 8) ? 0 : (r < 22) ? $urandom_range(0, 4095) : $urandom_range(1, 40);
        return make_entry(first, total,
                          ($urandom_range(0, 9) == 0) ? 1024 : $urandom_range(0, 1024),
                          ($urandom_range(0, 9) == 0) ? 1024 : $urandom_range(0, 1024),
                          $urandom_range(0, 1023), $urandom_range(0, 1023),
                          cols, $urandom_range(0, 65535));
    endfunction

    // an id near the range of the given tileset, sometimes just outside it
    function automatic id_t aim_id(tsrl_pkg::entry_t t);
        int     span;
        longint v;
        span = ($signed(t.tile_total) < 0) ? 4000 : int'($signed(t.tile_total)) + 8;
        v = longint'(t.first_id) + longint'($urandom_range(0, span)) - 4;
        if (v < 0) v = 0;
        if (v > MAX_ID) v = MAX_ID;
        return v[tsrl_pkg::ID_W-1:0];
    endfunction

    // drive one input transfer; entered and left at a falling edge
    task automatic send_item(cmd_t cmd, tsrl_pkg::entry_t e, id_t id);
        int gap;
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= {1'b0, id, e.atlas_texture, e.atlas_columns, e.gap, e.border,
                     e.cell_height, e.cell_width, e.tile_total, e.first_id};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        sb.accept_command(cmd, e, id);
        if (cmd != CMD_UNUSED) items_sent++;
        @(negedge aclk);
        gap = pick_gap(src_pace);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
    endtask

    task automatic send_lookup(id_t id);
        send_item(tsrl_pkg::CMD_LOOKUP, random_entry($urandom_range(0, MAX_ID)), id);
    endtask

    // sender stops offering until every owed rectangle has come back
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        do @(negedge aclk); while (sb.pending_rects.size() != 0);
    endtask

    // result side: check every accepted transfer at the rising edge
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) sb.check_rect(m_tuser, m_tdata);
    end

    // receiver ready pattern, with a long hold-off on request
    initial begin : sink_side
        int hold_left;
        hold_left = 0;
        forever begin
            @(negedge aclk);
            if (!aresetn) begin
                m_tready <= 1'b0;
            end else if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else if (sink_hold_req) begin
                sink_hold_req = 1'b0;
                hold_left = LONG_HOLD;
                m_tready <= 1'b0;
            end else begin
                hold_left = pick_gap(sink_pace);
                m_tready <= (hold_left == 0);
            end
        end
    end

    // watchdog: too long without a transfer on either side
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog expired, %0d rectangles still owed", sb.pending_rects.size());
            $display("TEST FAILED");
            $finish;
        end
    end

    initial begin : stimulus
        tsrl_pkg::entry_t built[0:8];
        tsrl_pkg::entry_t junk;
        longint      base;
        int          n_built, n_look, r, k;
        bit          held_early, held_late;
        held_early = 1'b0;
        held_late = 1'b0;

        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // directed part
        junk = random_entry(0);
        send_lookup(0);                                  // table empty
        send_item(CMD_UNUSED, junk, 24'd7);              // dropped, no result
        send_item(tsrl_pkg::CMD_APPEND,
                  make_entry(100, 10, 1024, 1024, 1023, 1023, 4095, 65535), 0);
        send_lookup(99);                                 // below the first tileset
        send_lookup(100);
        send_lookup(109);
        send_lookup(110);                                // past every range
        // empty range at the top id: catches lower ids with a negative relative id
        send_item(tsrl_pkg::CMD_APPEND,
                  make_entry(MAX_ID, 0, 1024, 1024, 1023, 1023, 3, 1234), 0);
        send_lookup(110);
        // unknown count catches the top id, row term clamps high
        send_item(tsrl_pkg::CMD_APPEND, make_entry(0, -1, 1024, 1024, 1023, 1023, 1, 77), 0);
        send_lookup(MAX_ID);
        send_item(tsrl_pkg::CMD_CLEAR, junk, 0);
        send_lookup(5);                                  // empty again after clear
        // fill the table; first entry has zero columns
        send_item(tsrl_pkg::CMD_APPEND, make_entry(0, 50, 16, 16, 0, 0, 0, 1), 0);
        for (k = 1; k < 7; k++)
            send_item(tsrl_pkg::CMD_APPEND,
                      make_entry(1000 * k, (k == 1) ? 65535 : 100, 32 * k,
                                 16 * k, k, k, k + 1, k + 1), 0);
        send_item(tsrl_pkg::CMD_APPEND,
                  make_entry(MAX_ID - 65535, 65535, 9, 5, 3, 2, 1, 4321), 0);
        // table full
        send_item(tsrl_pkg::CMD_APPEND, make_entry(0, -1, 1, 1, 1, 1, 5, 99), 0);
        send_lookup(20);                                 // zero columns
        send_lookup(MAX_ID);                             // would hit only the dropped entry
        send_lookup(MAX_ID - 1);
        wait_drained();

        // random part: mostly built tables with lookups aimed at them
        while (items_sent < ITEM_TARGET) begin
            src_pace  = pace_e'($urandom_range(0, 2));
            sink_pace = pace_e'($urandom_range(0, 2));
            r = $urandom_range(0, 99);
            if (r < 85) begin
                if ($urandom_range(0, 3) != 0) send_item(tsrl_pkg::CMD_CLEAR, random_entry(0), 0);
                r = $urandom_range(0, 99);
                base = (r < 30) ? $urandom_range(0, 1000) :
                       (r < 90) ? $urandom_range(0, MAX_ID) : MAX_ID - $urandom_range(0, 2000);
                n_built = $urandom_range(1, 9);
                for (k = 0; k < n_built; k++) begin
                    built[k] = random_entry(int'(base & MAX_ID));
                    send_item(tsrl_pkg::CMD_APPEND, built[k], id_t'($urandom_range(0, MAX_ID)));
                    if ($signed(built[k].tile_total) >= 0)
                        base += longint'($signed(built[k].tile_total));
                    r = $urandom_range(0, 99);
                    if (r < 15) base += $urandom_range(1, 300);        // hole between ranges
                    else if (r < 25) base -= $urandom_range(0, 50);    // overlap
                    if (base < 0) base = 0;
                end
                // long receiver hold while the sender keeps offering back to back
                if ((!held_early && items_sent > 300) || (!held_late && items_sent > 1100)) begin
                    if (held_early) held_late = 1'b1;
                    held_early = 1'b1;
                    src_pace = PACE_FULL;
                    sink_hold_req = 1'b1;
                    n_look = 40;
                end else begin
                    n_look = $urandom_range(4, 24);
                end
                for (k = 0; k < n_look; k++) begin
                    r = $urandom_range(0, 99);
                    if (r < 3)
                        send_item(CMD_UNUSED, random_entry(0), id_t'($urandom_range(0, MAX_ID)));
                    else if (r < 15) send_lookup(id_t'($urandom_range(0, MAX_ID)));
                    else send_lookup(aim_id(built[$urandom_range(0, n_built - 1)]));
                end
            end else begin
                // noise: any command with any fields
                n_look = $urandom_range(3, 10);
                for (k = 0; k < n_look; k++) begin
                    junk = random_entry($urandom_range(0, MAX_ID));
                    send_item(cmd_t'($urandom_range(0, 3)), junk,
                              id_t'($urandom_range(0, MAX_ID)));
                end
            end
            if ($urandom_range(0, 7) == 0) wait_drained();
        end

        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (sb.pending_rects.size() != 0)
            sb.report_mismatch("rectangles never delivered", sb.pending_rects.size(), 0);

        $display("covered %0d commands, %0d lookups (%0d found, %0d not found), %0d results checked",
                 items_sent, sb.lookups, sb.found_cnt, sb.lookups - sb.found_cnt,
                 sb.results_seen);
        $display("clamped positions %0d, appends dropped on a full table %0d",
                 sb.clamped, sb.dropped_appends);
        if (sb.errors == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
